// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
package spq_pkg;

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned VITAL_W = 7;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Command word
  typedef struct packed {
    logic               operation;
    logic [TAG_W-1:0]   entry_tag;
    logic [VITAL_W-1:0] vital;
    logic [PRIO_W-1:0]  priority_req;
  } cmd_word_t;

  // Response word
  typedef struct packed {
    logic [1:0]         status;
    logic [TAG_W-1:0]   out_tag;
    logic [VITAL_W-1:0] out_vital;
    logic [PRIO_W-1:0]  out_priority;
    logic [OCC_W-1:0]   occupancy;
  } rsp_word_t;

  // Control a cell shows its neighbors
  typedef struct packed {
    logic valid;  // cell holds an entry
    logic keep;   // entry stays put on the current enqueue
  } spq_link_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

// ===== rtl/spq_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
interface spq_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: row of sorted cells and response register.
//
//   channel | dir | word       | contents
//   cmd     | in  | cmd_word_t | operation, entry_tag, vital, priority_req
//   rsp     | out | rsp_word_t | status, out_tag, out_vital, out_priority, occupancy
//
// Each command is done in the cycle it is accepted: every cell compares its
// priority with the new one and shifts in the same edge, so one word per cycle
// while cmd.ready is high; the response appears in the output register next cycle.
// cmd.ready is low only while a response is held and rsp.ready is low.
// Synchronous reset empties all cells; no clearing pass is needed.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input logic clk,
  input logic rst,
  spq_chan_if.sink   cmd,
  spq_chan_if.source rsp
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  cmd_word_t  c;
  logic       accept;
  logic       full;
  logic       empty;
  spq_ctl_t   ctl;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [TAG_BITS+TAG_W-1:0] tag_in_wide;
  logic [TAG_BITS-1:0]       new_tag;
  logic [TAG_BITS+TAG_W-1:0] tag_out_wide;
  logic [CNT_W+OCC_W-1:0]    occ_wide;
  rsp_word_t  rsp_next;
  logic       rsp_valid;

  spq_link_t               links [CAPACITY];
  logic [TAG_BITS-1:0]     tags  [CAPACITY];
  logic [VITAL_W-1:0]      vitals[CAPACITY];
  logic [PRIO_W-1:0]       prios [CAPACITY];

  assign c      = cmd.data;
  assign accept = cmd.valid && cmd.ready;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  // Keep only the low TAG_BITS of the incoming tag
  assign tag_in_wide = {{TAG_BITS{1'b0}}, c.entry_tag};
  assign new_tag     = tag_in_wide[TAG_BITS-1:0];

  // Shift commands to the row
  assign ctl.enq = accept && (c.operation == OP_ENQ) && !full;
  assign ctl.deq = accept && (c.operation == OP_DEQ) && !empty;

  // Row of cells; head is cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_link_t           l_link, r_link;
    logic [TAG_BITS-1:0] l_tag, r_tag;
    logic [VITAL_W-1:0]  l_vital, r_vital;
    logic [PRIO_W-1:0]   l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_link  = '{valid: 1'b1, keep: 1'b1};
      assign l_tag   = '0;
      assign l_vital = '0;
      assign l_prio  = '0;
    end else begin : g_mid_l
      assign l_link  = links[i-1];
      assign l_tag   = tags[i-1];
      assign l_vital = vitals[i-1];
      assign l_prio  = prios[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_link  = '{valid: 1'b0, keep: 1'b0};
      assign r_tag   = '0;
      assign r_vital = '0;
      assign r_prio  = '0;
    end else begin : g_mid_r
      assign r_link  = links[i+1];
      assign r_tag   = tags[i+1];
      assign r_vital = vitals[i+1];
      assign r_prio  = prios[i+1];
    end

    spq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_tag    (new_tag),
      .new_vital  (c.vital),
      .new_prio   (c.priority_req),
      .left_link  (l_link),
      .left_tag   (l_tag),
      .left_vital (l_vital),
      .left_prio  (l_prio),
      .right_link (r_link),
      .right_tag  (r_tag),
      .right_vital(r_vital),
      .right_prio (r_prio),
      .link       (links[i]),
      .tag        (tags[i]),
      .vital      (vitals[i]),
      .prio       (prios[i])
    );
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (ctl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Response word
  assign tag_out_wide = {{TAG_W{1'b0}}, tags[0]};
  assign occ_wide     = {{OCC_W{1'b0}}, count_next};

  always_comb begin
    rsp_next           = '0;
    rsp_next.occupancy = occ_wide[OCC_W-1:0];
    if (c.operation == OP_ENQ) begin
      rsp_next.status = full ? ST_FULL : ST_ENQUEUED;
    end else if (empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status       = ST_DEQUEUED;
      rsp_next.out_tag      = tag_out_wide[TAG_W-1:0];
      rsp_next.out_vital    = vitals[0];
      rsp_next.out_priority = prios[0];
    end
  end

  // Output register
  assign cmd.ready = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.ready) begin
      rsp_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data <= rsp_next;
    end
  end

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module spq_cell #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spq_pkg::spq_ctl_t          ctl,
  input  logic [TAG_BITS-1:0]        new_tag,
  input  logic [spq_pkg::VITAL_W-1:0] new_vital,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  spq_pkg::spq_link_t         left_link,
  input  logic [TAG_BITS-1:0]        left_tag,
  input  logic [spq_pkg::VITAL_W-1:0] left_vital,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  spq_pkg::spq_link_t         right_link,
  input  logic [TAG_BITS-1:0]        right_tag,
  input  logic [spq_pkg::VITAL_W-1:0] right_vital,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output spq_pkg::spq_link_t         link,
  output logic [TAG_BITS-1:0]        tag,
  output logic [spq_pkg::VITAL_W-1:0] vital,
  output logic [spq_pkg::PRIO_W-1:0] prio
);
  import spq_pkg::*;

  logic valid;

  // Entry stays when it is at least as urgent as the incoming one
  assign link.valid = valid;
  assign link.keep  = valid && (prio <= new_prio);

  // Occupancy of the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.enq && !link.keep) begin
      valid <= left_link.valid;
    end else if (ctl.deq) begin
      valid <= right_link.valid;
    end
  end

  // Payload: take the new entry at the insert point, else shift
  always_ff @(posedge clk) begin
    if (ctl.enq && !link.keep) begin
      if (left_link.keep) begin
        tag   <= new_tag;
        vital <= new_vital;
        prio  <= new_prio;
      end else begin
        tag   <= left_tag;
        vital <= left_vital;
        prio  <= left_prio;
      end
    end else if (ctl.deq) begin
      tag   <= right_tag;
      vital <= right_vital;
      prio  <= right_prio;
    end
  end

endmodule

// ===== test/tb_stable_priority_queue.sv =====
// Testbench for the stable priority queue: directed, pressure and random tests with a scoreboard.
module tb_stable_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 480;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_chan_if #(.word_t(cmd_word_t)) cmd_if ();
  spq_chan_if #(.word_t(rsp_word_t)) rsp_if ();

  stable_priority_queue #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the sorted queue
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [VITAL_W-1:0] vital;
    logic [PRIO_W-1:0]  prio;
  } slot_t;

  slot_t       slots [CAPACITY];
  int unsigned slot_count = 0;

  rsp_word_t   rsp_due[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent, and the receiver hold-off request
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 57;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;

  // Apply one command to the shadow queue and return the response it should give
  function automatic rsp_word_t apply_cmd(cmd_word_t w);
    rsp_word_t   r;
    int unsigned pos;
    r = '0;
    if (w.operation == OP_ENQ) begin
      if (slot_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // stable insert: goes behind every entry of equal or more urgent priority
        pos = 0;
        while (pos < slot_count && slots[pos].prio <= w.priority_req) pos++;
        for (int unsigned i = slot_count; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].tag   = w.entry_tag;
        slots[pos].vital = w.vital;
        slots[pos].prio  = w.priority_req;
        slot_count++;
        r.status = ST_ENQUEUED;
      end
    end else begin
      if (slot_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status       = ST_DEQUEUED;
        r.out_tag      = slots[0].tag;
        r.out_vital    = slots[0].vital;
        r.out_priority = slots[0].prio;
        for (int unsigned i = 1; i < slot_count; i++) slots[i-1] = slots[i];
        slot_count--;
      end
    end
    r.occupancy = OCC_W'(slot_count);
    return r;
  endfunction

  // Send one command word; returns at the edge where it is accepted
  task automatic send_cmd(cmd_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    do @(posedge clk); while (!cmd_if.ready);
    rsp_due.push_back(apply_cmd(w));
  endtask

  task automatic send_enq(logic [TAG_W-1:0] tag, logic [VITAL_W-1:0] vital,
                          logic [PRIO_W-1:0] prio);
    cmd_word_t w;
    w.operation    = OP_ENQ;
    w.entry_tag    = tag;
    w.vital        = vital;
    w.priority_req = prio;
    send_cmd(w);
  endtask

  task automatic send_deq();
    cmd_word_t w;
    w              = cmd_word_t'($urandom);
    w.operation    = OP_DEQ;
    send_cmd(w);
  endtask

  // Stop offering words and wait for every outstanding response
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  // Response checker and receiver-side ready
  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $realtime, got);
        error_count++;
      end else begin
        want = rsp_due.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
          error_count++;
        end
        if (got.out_tag !== want.out_tag) begin
          $display("%0t: out_tag expected %h actual %h", $realtime, want.out_tag, got.out_tag);
          error_count++;
        end
        if (got.out_vital !== want.out_vital) begin
          $display("%0t: out_vital expected %0d actual %0d", $realtime,
                   want.out_vital, got.out_vital);
          error_count++;
        end
        if (got.out_priority !== want.out_priority) begin
          $display("%0t: out_priority expected %0d actual %0d", $realtime,
                   want.out_priority, got.out_priority);
          error_count++;
        end
        if (got.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $realtime,
                   want.occupancy, got.occupancy);
          error_count++;
        end
      end
    end
    // long hold-off has priority over random stalls
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Dequeue on an empty queue right after reset
  task automatic test_empty_dequeue();
    send_deq();
    wait_drained();
  endtask

  // Priority order, arrival order within a priority, field extremes
  task automatic test_ordering();
    send_enq(16'hFFFF, 7'd100, 2'd3);
    send_enq(16'h0000, 7'd0,   2'd1);
    send_enq(16'hA5A5, 7'd127, 2'd2);
    send_enq(16'h5A5A, 7'd101, 2'd1);
    send_enq(16'h1234, 7'd55,  2'd0);   // priority zero beats everything
    send_enq(16'h8001, 7'd1,   2'd3);
    send_enq(16'h7FFE, 7'd64,  2'd0);
    repeat (8) send_deq();               // the last one hits an empty queue
    wait_drained();
  endtask

  // Receiver stalls a long time while the sender overfills the queue
  task automatic test_fill_under_stall();
    hold_req = 120;
    for (int i = 0; i < CAPACITY + 4; i++) begin
      send_enq(TAG_W'($urandom), VITAL_W'($urandom), PRIO_W'($urandom_range(0, 3)));
    end
    wait_drained();
    repeat (CAPACITY + 1) send_deq();
    wait_drained();
  endtask

  // Random mix; enqueue bias changes per burst so the queue swings full and empty
  task automatic test_random_mix(int unsigned n_items);
    int unsigned enq_pct;
    cmd_word_t   w;
    enq_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      w           = cmd_word_t'($urandom);
      w.operation = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      send_cmd(w);
    end
    wait_drained();
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_dequeue();
    test_ordering();
    test_fill_under_stall();

    send_idle_pct = 12;
    recv_idle_pct = 57;
    test_random_mix(PHASE_ITEMS);
    send_idle_pct = 57;
    recv_idle_pct = 12;
    test_random_mix(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(PHASE_ITEMS);

    // keep the clock running to catch stray responses
    repeat (10) @(posedge clk);
    if (error_count == 0 && rsp_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_chan_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
test/tb_stable_priority_queue.sv
